@@ src/tim_pkg.sv @@
// Shared types and constants for the time interval meter.
package tim_pkg;

  // Field and register widths.
  localparam int STAMP_W   = 64;
  localparam int TIMEOUT_W = 16;
  localparam int HZ_W      = 32;
  localparam int CFG_W     = 32;

  // Nanoseconds per second, fits in 30 bits.
  localparam int NS_W = 30;
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Width of one partial product (32-bit half by the 30-bit constant).
  localparam int PROD_W = HZ_W + NS_W;
  // Width of the full product plus rounding term.
  localparam int ACC_W = STAMP_W + HZ_W;

  // Long division produces one quotient bit per step.
  localparam int DIV_STEPS = STAMP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register reset values.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd200;
  localparam logic [HZ_W-1:0]      HZ_RST      = 32'd84000000;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = '1;

  // Input item kinds; code 3 is unused.
  typedef enum logic [1:0] {
    KIND_A    = 2'd0,
    KIND_B    = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_HZ      = 1'b1
  } reg_idx_t;

  // Top level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } top_state_t;

  // Conversion unit sequencer.
  typedef enum logic [2:0] {
    CV_IDLE,
    CV_MUL_LO,
    CV_ADD_LO,
    CV_MUL_HI,
    CV_ADD_HI,
    CV_CHECK,
    CV_DIV
  } conv_state_t;

  // Request from the sequencer to the conversion unit.
  typedef struct packed {
    logic               start;
    logic [STAMP_W-1:0] ticks;
    logic [HZ_W-1:0]    hz;
  } conv_req_t;

  // Response from the conversion unit.
  typedef struct packed {
    logic               done;
    logic [STAMP_W-1:0] ns;
  } conv_rsp_t;

endpackage

@@ src/time_interval_meter.sv @@
// Top level of the time interval meter: event sequencer, state, output register.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | in_kind, in_timestamp
//  out_    | output    | out_valid/stall  | valid_res, waiting, span_ticks, span_ns
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// An A edge, a tick, an unused kind or a B edge that is ignored or late loads the output
// register directly. A B edge that closes a pair holds the input through the conversion:
// five setup steps and the 64-step serial divider; a saturated quotient skips the divider.
// Reset is synchronous and active low; it restores both registers and clears the sequencer,
// measurement state and output valid flag. Input is stalled while a conversion or its delivery
// is pending or the output register holds a stalled result. The configuration port is always ready.
module time_interval_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic        out_waiting,
  output logic [63:0] out_span_ticks,
  output logic [63:0] out_span_ns,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  tim_pkg::top_state_t state_r, state_nxt;

  // Configuration registers.
  logic [tim_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [tim_pkg::HZ_W-1:0]      hz_r;

  // Measurement state.
  logic                          waiting_r, waiting_nxt;
  logic [tim_pkg::STAMP_W-1:0]   start_r, start_nxt;
  logic [tim_pkg::TIMEOUT_W-1:0] elapsed_r, elapsed_nxt;
  logic [tim_pkg::STAMP_W-1:0]   ticks_r, ticks_nxt;
  logic [tim_pkg::STAMP_W-1:0]   ns_r, ns_nxt;
  logic                          vflag_r, vflag_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_vres_r;
  logic                        out_wait_r;
  logic [tim_pkg::STAMP_W-1:0] out_ticks_r;
  logic [tim_pkg::STAMP_W-1:0] out_ns_r;

  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic [tim_pkg::TIMEOUT_W-1:0] elapsed_inc;
  tim_pkg::conv_req_t            conv_req;
  tim_pkg::conv_rsp_t            conv_rsp;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != tim_pkg::ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;

  // Elapsed milliseconds saturate at the counter's top value.
  assign elapsed_inc = (elapsed_r < tim_pkg::ELAPSED_MAX) ?
                       elapsed_r + tim_pkg::TIMEOUT_W'(1) : elapsed_r;

  tim_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .rsp   (conv_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= tim_pkg::TIMEOUT_RST;
      hz_r      <= tim_pkg::HZ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tim_pkg::reg_idx_t'(cfg_index))
        tim_pkg::REG_TIMEOUT: timeout_r <= cfg_data[tim_pkg::TIMEOUT_W-1:0];
        tim_pkg::REG_HZ:      hz_r      <= cfg_data[tim_pkg::HZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and measurement state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tim_pkg::ST_IDLE;
      waiting_r   <= 1'b0;
      start_r     <= '0;
      elapsed_r   <= '0;
      ticks_r     <= '0;
      ns_r        <= '0;
      vflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      waiting_r   <= waiting_nxt;
      start_r     <= start_nxt;
      elapsed_r   <= elapsed_nxt;
      ticks_r     <= ticks_nxt;
      ns_r        <= ns_nxt;
      vflag_r     <= vflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload takes the state after each transaction.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vres_r  <= vflag_nxt;
      out_wait_r  <= waiting_nxt;
      out_ticks_r <= ticks_nxt;
      out_ns_r    <= ns_nxt;
    end
  end

  // Next state: event handling, conversion wait and result delivery.
  always_comb begin
    state_nxt     = state_r;
    waiting_nxt   = waiting_r;
    start_nxt     = start_r;
    elapsed_nxt   = elapsed_r;
    ticks_nxt     = ticks_r;
    ns_nxt        = ns_r;
    vflag_nxt     = vflag_r;
    out_load      = 1'b0;
    conv_req.start = 1'b0;
    conv_req.ticks = in_timestamp - start_r;
    conv_req.hz    = hz_r;
    case (state_r)
      tim_pkg::ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (tim_pkg::kind_t'(in_kind))
            tim_pkg::KIND_A: begin
              if (!waiting_r) begin
                vflag_nxt   = 1'b0;
                ticks_nxt   = '0;
                ns_nxt      = '0;
                start_nxt   = in_timestamp;
                elapsed_nxt = '0;
                waiting_nxt = 1'b1;
              end
            end
            tim_pkg::KIND_B: begin
              if (waiting_r) begin
                if (elapsed_r > timeout_r) begin
                  // Late stop edge drops everything.
                  waiting_nxt = 1'b0;
                  start_nxt   = '0;
                  elapsed_nxt = '0;
                  ticks_nxt   = '0;
                  ns_nxt      = '0;
                  vflag_nxt   = 1'b0;
                end else begin
                  ticks_nxt      = in_timestamp - start_r;
                  vflag_nxt      = 1'b1;
                  waiting_nxt    = 1'b0;
                  conv_req.start = 1'b1;
                  out_load       = 1'b0;
                  state_nxt      = tim_pkg::ST_CONV;
                end
              end
            end
            tim_pkg::KIND_TICK: begin
              if (waiting_r) begin
                if (elapsed_inc > timeout_r) begin
                  // Timeout drops everything.
                  waiting_nxt = 1'b0;
                  start_nxt   = '0;
                  elapsed_nxt = '0;
                  ticks_nxt   = '0;
                  ns_nxt      = '0;
                  vflag_nxt   = 1'b0;
                end else begin
                  elapsed_nxt = elapsed_inc;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      tim_pkg::ST_CONV: begin
        if (conv_rsp.done) begin
          ns_nxt    = conv_rsp.ns;
          state_nxt = tim_pkg::ST_EMIT;
        end
      end
      tim_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = tim_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tim_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_vres_r;
  assign out_waiting    = out_wait_r;
  assign out_span_ticks = out_ticks_r;
  assign out_span_ns    = out_ns_r;

  // A valid result always closes the pair, so it never reports waiting.
  a_valid_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vres_r) |-> !out_wait_r)
    else $error("valid result reported while still waiting");

  // A stalled result stays valid and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_vres_r) &&
      $stable(out_wait_r) && $stable(out_ticks_r) && $stable(out_ns_r)))
    else $error("stalled result changed");

  // No input is taken while a conversion or its delivery is pending.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tim_pkg::ST_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

endmodule

@@ src/tim_conv.sv @@
// Tick to nanosecond converter: shared multiplier, adder and serial divider.
module tim_conv (
  input  logic              clk,
  input  logic              rst_n,
  input  tim_pkg::conv_req_t req,
  output tim_pkg::conv_rsp_t rsp
);

  tim_pkg::conv_state_t state_r, state_nxt;

  logic [tim_pkg::STAMP_W-1:0]   ticks_r, ticks_nxt;
  logic [tim_pkg::HZ_W-1:0]      hz_r, hz_nxt;
  logic [tim_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [tim_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic [tim_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tim_pkg::STAMP_W-1:0]   ns_r, ns_nxt;
  logic                          done_r, done_nxt;

  logic [tim_pkg::HZ_W-1:0]   mul_a;
  logic [tim_pkg::ACC_W-1:0]  add_a, add_b, add_sum;
  logic [tim_pkg::HZ_W:0]     rem_sh;
  logic [tim_pkg::HZ_W:0]     rem_diff;
  logic                       rem_ge;
  logic [tim_pkg::HZ_W-1:0]   rem_new;
  logic [tim_pkg::ACC_W-1:0]  div_next;

  // Shared multiplier: one 32-bit half of the ticks by one billion.
  assign mul_a    = (state_r == tim_pkg::CV_MUL_HI) ? ticks_r[tim_pkg::STAMP_W-1:tim_pkg::HZ_W]
                                                    : ticks_r[tim_pkg::HZ_W-1:0];
  assign prod_nxt = tim_pkg::PROD_W'(mul_a) * tim_pkg::PROD_W'(tim_pkg::NS_PER_SEC);

  // Shared adder: first the low product plus half of hz, then the high product shifted up.
  always_comb begin
    if (state_r == tim_pkg::CV_ADD_HI) begin
      add_a = acc_r;
      add_b = tim_pkg::ACC_W'({prod_r, {tim_pkg::HZ_W{1'b0}}});
    end else begin
      add_a = tim_pkg::ACC_W'(prod_r);
      add_b = tim_pkg::ACC_W'(hz_r >> 1);
    end
  end
  assign add_sum = add_a + add_b;

  // One restoring division step; the low half of the accumulator collects the quotient.
  assign rem_sh   = {acc_r[tim_pkg::ACC_W-1:tim_pkg::STAMP_W], acc_r[tim_pkg::STAMP_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, hz_r};
  assign rem_diff = rem_sh - {1'b0, hz_r};
  assign rem_new  = rem_ge ? rem_diff[tim_pkg::HZ_W-1:0] : rem_sh[tim_pkg::HZ_W-1:0];
  assign div_next = {rem_new, acc_r[tim_pkg::STAMP_W-2:0], rem_ge};

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tim_pkg::CV_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    ticks_r <= ticks_nxt;
    hz_r    <= hz_nxt;
    if (state_r == tim_pkg::CV_MUL_LO || state_r == tim_pkg::CV_MUL_HI) begin
      prod_r <= prod_nxt;
    end
    acc_r   <= acc_nxt;
    ns_r    <= ns_nxt;
  end

  // Sequencer: two multiplies, two adds, an overflow check, then the divide unless saturated.
  always_comb begin
    state_nxt = state_r;
    ticks_nxt = ticks_r;
    hz_nxt    = hz_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ns_nxt    = ns_r;
    done_nxt  = 1'b0;
    case (state_r)
      tim_pkg::CV_IDLE: begin
        if (req.start) begin
          ticks_nxt = req.ticks;
          hz_nxt    = req.hz;
          state_nxt = tim_pkg::CV_MUL_LO;
        end
      end
      tim_pkg::CV_MUL_LO: begin
        state_nxt = tim_pkg::CV_ADD_LO;
      end
      tim_pkg::CV_ADD_LO: begin
        acc_nxt   = add_sum;
        state_nxt = tim_pkg::CV_MUL_HI;
      end
      tim_pkg::CV_MUL_HI: begin
        state_nxt = tim_pkg::CV_ADD_HI;
      end
      tim_pkg::CV_ADD_HI: begin
        acc_nxt   = add_sum;
        state_nxt = tim_pkg::CV_CHECK;
      end
      tim_pkg::CV_CHECK: begin
        // A quotient that cannot fit, or a zero frequency, saturates.
        if (acc_r[tim_pkg::ACC_W-1:tim_pkg::STAMP_W] >= hz_r) begin
          ns_nxt    = '1;
          done_nxt  = 1'b1;
          state_nxt = tim_pkg::CV_IDLE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = tim_pkg::CV_DIV;
        end
      end
      tim_pkg::CV_DIV: begin
        acc_nxt = div_next;
        cnt_nxt = cnt_r + tim_pkg::DIV_CNT_W'(1);
        if (cnt_r == tim_pkg::DIV_CNT_W'(tim_pkg::DIV_STEPS - 1)) begin
          ns_nxt    = div_next[tim_pkg::STAMP_W-1:0];
          done_nxt  = 1'b1;
          state_nxt = tim_pkg::CV_IDLE;
        end
      end
      default: begin
        state_nxt = tim_pkg::CV_IDLE;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.ns   = ns_r;

  // The completion strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("conversion done held for more than one cycle");

  // A new request only arrives while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == tim_pkg::CV_IDLE)
    else $error("conversion started while busy");

  // A zero frequency always reports all ones.
  a_zero_hz: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && hz_r == '0) |-> ns_r == '1)
    else $error("zero frequency did not saturate");

endmodule

@@ dv/tb_time_interval_meter.sv @@
// Self-checking testbench for the time interval meter: random and directed edges, ticks and config.
`timescale 1ns / 1ps

// Expected contents of one output transaction.
typedef struct {
  logic        valid_res;
  logic        waiting;
  logic [63:0] ticks;
  logic [63:0] ns;
} interval_result_t;

// Tracks the meter state and the intervals still to come out of the block.
class interval_tracker;
  logic [15:0]      timeout_ms;
  logic [31:0]      counter_hz;
  logic             waiting;
  logic [63:0]      start_stamp;
  logic [15:0]      elapsed_ms;
  logic [63:0]      ticks_result;
  logic [63:0]      ns_result;
  logic             valid_flag;
  interval_result_t pending[$];
  int               errors;

  function new();
    timeout_ms = 16'd200;
    counter_hz = 32'd84000000;
    errors     = 0;
    clear_pairing();
  endfunction

  function void clear_pairing();
    waiting      = 1'b0;
    start_stamp  = '0;
    elapsed_ms   = '0;
    ticks_result = '0;
    ns_result    = '0;
    valid_flag   = 1'b0;
  endfunction

  function void set_reg(tim_pkg::reg_idx_t idx, logic [31:0] data);
    case (idx)
      tim_pkg::REG_TIMEOUT: timeout_ms = data[15:0];
      tim_pkg::REG_HZ:      counter_hz = data;
      default: ;
    endcase
  endfunction

  // Rounded ticks * 1e9 / hz through a wide product; saturates on overflow or a zero hz.
  function logic [63:0] ticks_to_ns(logic [63:0] ticks, logic [31:0] hz);
    logic [127:0] num;
    logic [127:0] quo;
    if (hz == '0) return '1;
    num = 128'(ticks) * 128'd1000000000 + 128'(hz >> 1);
    quo = num / 128'(hz);
    if (quo[127:64] != '0) return '1;
    return quo[63:0];
  endfunction

  // Applies one accepted input transaction and queues the state it reports.
  function void take_event(logic [1:0] kind, logic [63:0] stamp);
    interval_result_t r;
    case (kind)
      tim_pkg::KIND_A: begin
        if (!waiting) begin
          valid_flag   = 1'b0;
          ticks_result = '0;
          ns_result    = '0;
          start_stamp  = stamp;
          elapsed_ms   = '0;
          waiting      = 1'b1;
        end
      end
      tim_pkg::KIND_B: begin
        if (waiting) begin
          if (elapsed_ms > timeout_ms) begin
            clear_pairing();
          end else begin
            ticks_result = stamp - start_stamp;
            ns_result    = ticks_to_ns(ticks_result, counter_hz);
            valid_flag   = 1'b1;
            waiting      = 1'b0;
          end
        end
      end
      tim_pkg::KIND_TICK: begin
        if (waiting) begin
          if (elapsed_ms != '1) elapsed_ms++;
          if (elapsed_ms > timeout_ms) clear_pairing();
        end
      end
      default: ;
    endcase
    r.valid_res = valid_flag;
    r.waiting   = waiting;
    r.ticks     = ticks_result;
    r.ns        = ns_result;
    pending.push_back(r);
  endfunction

  function void flag(string what, logic [63:0] exp_val, logic [63:0] act_val);
    errors++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_val, act_val);
  endfunction

  // Compares one output transaction with the oldest expected interval.
  function void match_result(logic vr, logic wt, logic [63:0] ticks, logic [63:0] ns);
    interval_result_t r;
    if (pending.size() == 0) begin
      flag("unexpected result, valid_res", '0, 64'(vr));
      return;
    end
    r = pending.pop_front();
    if (vr !== r.valid_res) flag("valid_res", 64'(r.valid_res), 64'(vr));
    if (wt !== r.waiting) flag("waiting", 64'(r.waiting), 64'(wt));
    if (ticks !== r.ticks) flag("span_ticks", r.ticks, ticks);
    if (ns !== r.ns) flag("span_ns", r.ns, ns);
  endfunction
endclass

module tb_time_interval_meter;

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 100;
  localparam int         CYCLE_LIMIT   = 3000000;
  localparam int         PHASE_ITEMS   = 140;
  localparam int         PHASES        = 12;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [63:0] in_timestamp;
  logic        out_valid;
  logic        out_stall;
  logic        out_valid_res;
  logic        out_waiting;
  logic [63:0] out_span_ticks;
  logic [63:0] out_span_ns;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  interval_tracker tracker;
  int              idle_max;
  int              hold_cycles;
  int              sent_items;
  int              cycle_count;

  time_interval_meter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_timestamp  (in_timestamp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_waiting   (out_waiting),
    .out_span_ticks(out_span_ticks),
    .out_span_ns   (out_span_ns),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offers one input transaction after a random gap and waits until it is taken.
  task automatic drive_event(logic [1:0] kind, logic [63:0] stamp);
    int gap;
    gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_timestamp <= stamp;
    do @(posedge clk); while (in_stall);
    tracker.take_event(kind, stamp);
    sent_items++;
    @(negedge clk);
  endtask

  // Stops offering input, waits for every expected result, then lets the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one configuration register; only called while the block is idle.
  task automatic write_reg(tim_pkg::reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One A to B pairing with random ticks and content, or a single noise transaction.
  task automatic run_sequence(int unsigned tmo);
    logic [63:0] a_stamp;
    logic [63:0] b_stamp;
    int unsigned n_ticks;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      drive_event(2'($urandom_range(0, 3)), rand64());
      return;
    end
    a_stamp = rand64();
    drive_event(tim_pkg::KIND_A, a_stamp);
    if (tmo <= 20) n_ticks = $urandom_range(0, tmo + 2);
    else if (roll < 30 && tmo <= 300) n_ticks = $urandom_range(tmo - 3, tmo + 3);
    else n_ticks = $urandom_range(0, 6);
    repeat (n_ticks) begin
      if ($urandom_range(0, 15) == 0) drive_event(tim_pkg::KIND_A, rand64());
      drive_event(tim_pkg::KIND_TICK, rand64());
    end
    case ($urandom_range(0, 2))
      0:       b_stamp = a_stamp + 64'($urandom_range(0, 100000));
      1:       b_stamp = rand64();
      default: b_stamp = a_stamp + {32'd0, $urandom};
    endcase
    drive_event(tim_pkg::KIND_B, b_stamp);
  endtask

  // Result side: random stalls, one long hold-off on request, check of each transaction.
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.match_result(out_valid_res, out_waiting, out_span_ticks, out_span_ns);
    end
  end

  // Reset, directed cases, random phases and the final verdict.
  initial begin
    logic [15:0] tmo;
    logic [31:0] hz;
    int          phase_start;
    tracker      = new();
    idle_max     = 5;
    hold_cycles  = 0;
    sent_items   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = tim_pkg::KIND_A;
    in_timestamp = '0;
    cfg_valid    = 1'b0;
    cfg_index    = tim_pkg::REG_TIMEOUT;
    cfg_data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settle();

    // Unused kind, B and tick while idle.
    drive_event(KIND_UNUSED, rand64());
    drive_event(tim_pkg::KIND_B, '1);
    drive_event(tim_pkg::KIND_TICK, '0);
    // Extreme interval saturates the nanosecond result; a second A is ignored.
    drive_event(tim_pkg::KIND_A, '0);
    drive_event(tim_pkg::KIND_A, '1);
    drive_event(tim_pkg::KIND_TICK, '0);
    drive_event(tim_pkg::KIND_B, '1);
    // Wrapping timestamps and a zero interval.
    drive_event(tim_pkg::KIND_A, '1);
    drive_event(tim_pkg::KIND_B, '0);
    drive_event(tim_pkg::KIND_A, 64'h5);
    drive_event(tim_pkg::KIND_B, 64'h5);

    // Zero timeout: one tick drops the pairing, an immediate B still closes it.
    settle();
    write_reg(tim_pkg::REG_TIMEOUT, 32'd0);
    drive_event(tim_pkg::KIND_A, rand64());
    drive_event(tim_pkg::KIND_TICK, rand64());
    drive_event(tim_pkg::KIND_A, 64'd1000);
    drive_event(tim_pkg::KIND_B, 64'd2000);

    // Late B after the timeout was lowered below the elapsed count.
    settle();
    write_reg(tim_pkg::REG_TIMEOUT, 32'hFFFF0002);
    drive_event(tim_pkg::KIND_A, rand64());
    drive_event(tim_pkg::KIND_TICK, '0);
    drive_event(tim_pkg::KIND_TICK, '0);
    settle();
    write_reg(tim_pkg::REG_TIMEOUT, 32'd1);
    drive_event(tim_pkg::KIND_B, rand64());

    // Zero frequency, then the frequency extremes.
    settle();
    write_reg(tim_pkg::REG_HZ, 32'd0);
    drive_event(tim_pkg::KIND_A, rand64());
    drive_event(tim_pkg::KIND_B, rand64());
    settle();
    write_reg(tim_pkg::REG_HZ, '1);
    drive_event(tim_pkg::KIND_A, '0);
    drive_event(tim_pkg::KIND_B, '1);
    settle();
    write_reg(tim_pkg::REG_HZ, 32'd1);
    drive_event(tim_pkg::KIND_A, '0);
    drive_event(tim_pkg::KIND_B, 64'd1000);

    // Random phases, each with its own register settings and idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 6)
        0:       tmo = 16'd0;
        1:       tmo = 16'd1;
        2:       tmo = 16'($urandom_range(2, 12));
        3:       tmo = 16'd200;
        4:       tmo = 16'd65535;
        default: tmo = 16'($urandom);
      endcase
      case (p % 5)
        0:       hz = 32'd1;
        1:       hz = '1;
        2:       hz = 32'd84000000;
        3:       hz = $urandom;
        default: hz = $urandom_range(1, 1000);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(tim_pkg::REG_TIMEOUT, {16'($urandom), tmo});
        write_reg(tim_pkg::REG_HZ, hz);
      end else begin
        write_reg(tim_pkg::REG_HZ, hz);
        write_reg(tim_pkg::REG_TIMEOUT, {16'($urandom), tmo});
      end
      idle_max = (p % 3 == 2) ? 0 : 5;
      if (p == 4) hold_cycles = 400;
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) run_sequence(32'(tmo));
    end

    settle();
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tim_pkg.sv
src/tim_conv.sv
src/time_interval_meter.sv
dv/tb_time_interval_meter.sv
